// ===== rtl/grc_pkg.sv =====
package grc_pkg;

    localparam int DEF_NODES = 64;
    localparam int ACTION_W  = 2;
    localparam int NODE_ID_W = 6;
    localparam int COUNT_W   = 7;

    typedef enum logic [ACTION_W-1:0] {
        ACT_ADD   = 2'd0,
        ACT_CLEAR = 2'd1,
        ACT_WALK  = 2'd2
    } t_action;

    typedef struct packed {
        t_action                action;
        logic [NODE_ID_W-1:0]   from_node;
        logic [NODE_ID_W-1:0]   to_node;
    } t_in;

    typedef struct packed {
        logic [COUNT_W-1:0]     reachable_count;
        logic                   walk_done;
    } t_out;

    // control from the sequencer to the adjacency store
    typedef struct packed {
        logic rd;
        logic wr;
        logic clr;
    } t_adj_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ADD_WR,
        ST_CLEAR,
        ST_POP,
        ST_FETCH,
        ST_SCAN,
        ST_RESULT
    } t_state;

endpackage

// ===== rtl/grc_adj_store.sv =====
module grc_adj_store
    import grc_pkg::*;
#(
    parameter int NODES = DEF_NODES
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_adj_ctl                   i_ctl,
    input  logic [$clog2(NODES)-1:0]   i_addr,
    input  logic [NODES-1:0]           i_wdata,
    output logic [NODES-1:0]           o_rdata,
    output logic                       o_busy
);

    localparam int NODE_W = $clog2(NODES);

    logic [NODES-1:0]  r_rows [NODES];
    logic [NODES-1:0]  r_rdata;
    logic              r_sweep;
    logic [NODE_W-1:0] r_sweep_addr;

    // zeroing pass, one row per cycle, after reset and on a clear request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sweep      <= 1'b1;
            r_sweep_addr <= '0;
        end else if (i_ctl.clr) begin
            r_sweep      <= 1'b1;
            r_sweep_addr <= '0;
        end else if (r_sweep) begin
            if (r_sweep_addr == NODE_W'(NODES - 1)) begin
                r_sweep <= 1'b0;
            end
            r_sweep_addr <= r_sweep_addr + NODE_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_sweep) begin
            r_rows[r_sweep_addr] <= '0;
        end else if (i_ctl.wr) begin
            r_rows[i_addr] <= i_wdata;
        end
        if (i_ctl.rd) begin
            r_rdata <= r_rows[i_addr];
        end
    end

    assign o_rdata = r_rdata;
    assign o_busy  = r_sweep;

endmodule

// ===== rtl/graph_reachability_counter_top.sv =====
// Directed-graph reachability counter. Edges live in a NODES x NODES bit memory;
// action 0 sets one edge, action 1 removes every edge, action 2 runs a depth-first
// walk from from_node and returns the number of distinct nodes reached (source
// included), and every transaction yields exactly one result. After reset and
// after each clear the adjacency memory is zeroed one row per cycle, during which
// no input transaction is taken. Steps per item: an edge add does a row read, a
// row write and the result; a clear waits out the zeroing pass. A walk, for
// each node, pops the stack into a register, reads its row from the single-port
// adjacency memory and pushes each newly found neighbor, one per cycle; once the
// stack is empty the result follows. A finished result waits in an output
// register, so the next transaction can be taken while it is still pending.
module graph_reachability_counter_top
    import grc_pkg::*;
#(
    parameter int NODES = DEF_NODES
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    input  t_in  i_in,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_out o_out
);

    localparam int NODE_W = $clog2(NODES);
    localparam int SP_W   = $clog2(NODES + 1);
    localparam int CNT_W  = $clog2(NODES + 1);

    t_state            r_state, n_state;
    t_adj_ctl          w_ctl;
    logic [NODE_W-1:0] w_adj_addr;
    logic [NODES-1:0]  w_adj_wdata;
    logic [NODES-1:0]  w_adj_rdata;
    logic              w_adj_busy;

    logic              w_in_ready;
    logic              w_accept;
    logic              w_src_ok;
    logic              w_add_ok;
    logic [NODE_W-1:0] w_src;
    logic [NODE_W-1:0] w_dst;

    logic [NODE_W-1:0] r_from;
    logic [NODE_W-1:0] r_to;
    logic [NODES-1:0]  r_visited;
    logic [CNT_W-1:0]  r_count;
    logic              r_walk;
    logic [SP_W-1:0]   r_sp;
    logic [SP_W-1:0]   w_sp_dec;

    logic [NODE_W-1:0] r_stack [NODES];
    logic [NODE_W-1:0] r_stack_q;
    logic              w_push;
    logic [NODE_W-1:0] w_push_addr;
    logic [NODE_W-1:0] w_push_data;
    logic              w_pop;

    logic [NODES-1:0]  w_pend;
    logic [NODES-1:0]  w_low;
    logic              w_any;
    logic [NODE_W-1:0] w_idx;

    logic              r_out_valid;
    t_out              r_out;
    logic              w_slot_free;

    grc_adj_store #(
        .NODES (NODES)
    ) u_adj (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_addr  (w_adj_addr),
        .i_wdata (w_adj_wdata),
        .o_rdata (w_adj_rdata),
        .o_busy  (w_adj_busy)
    );

    assign w_in_ready  = (r_state == ST_IDLE) && !w_adj_busy;
    assign o_in_ready  = w_in_ready;
    assign w_accept    = i_in_valid && w_in_ready;
    assign w_src_ok    = int'(i_in.from_node) < NODES;
    assign w_add_ok    = w_src_ok && (int'(i_in.to_node) < NODES);
    assign w_src       = NODE_W'(i_in.from_node);
    assign w_dst       = NODE_W'(i_in.to_node);
    assign w_sp_dec    = r_sp - SP_W'(1);
    assign w_slot_free = !r_out_valid || i_out_ready;

    // neighbors of the current node not yet visited, lowest one first
    assign w_pend = w_adj_rdata & ~r_visited;
    assign w_low  = w_pend & (~w_pend + NODES'(1));
    assign w_any  = |w_pend;

    always_comb begin
        w_idx = '0;
        for (int i = 0; i < NODES; i++) begin
            if (w_low[i]) begin
                w_idx = w_idx | NODE_W'(i);
            end
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    case (i_in.action)
                        ACT_ADD:   n_state = w_add_ok ? ST_ADD_WR : ST_RESULT;
                        ACT_CLEAR: n_state = ST_CLEAR;
                        ACT_WALK:  n_state = w_src_ok ? ST_POP : ST_RESULT;
                        default:   n_state = ST_RESULT;
                    endcase
                end
            end
            ST_ADD_WR: n_state = ST_RESULT;
            ST_CLEAR: begin
                if (!w_adj_busy) begin
                    n_state = ST_RESULT;
                end
            end
            ST_POP:   n_state = (r_sp == '0) ? ST_RESULT : ST_FETCH;
            ST_FETCH: n_state = ST_SCAN;
            ST_SCAN:  n_state = w_any ? ST_SCAN : ST_POP;
            ST_RESULT: begin
                if (w_slot_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        w_ctl       = '0;
        w_adj_addr  = r_from;
        w_adj_wdata = '0;
        w_push      = 1'b0;
        w_push_addr = r_sp[NODE_W-1:0];
        w_push_data = w_idx;
        w_pop       = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                w_adj_addr = w_src;
                if (w_accept) begin
                    case (i_in.action)
                        ACT_ADD:   w_ctl.rd = w_add_ok;
                        ACT_CLEAR: w_ctl.clr = 1'b1;
                        ACT_WALK: begin
                            w_push      = w_src_ok;
                            w_push_addr = '0;
                            w_push_data = w_src;
                        end
                        default: ;
                    endcase
                end
            end
            ST_ADD_WR: begin
                w_ctl.wr    = 1'b1;
                w_adj_wdata = w_adj_rdata | (NODES'(1) << r_to);
            end
            ST_POP: w_pop = (r_sp != '0);
            ST_FETCH: begin
                w_ctl.rd   = 1'b1;
                w_adj_addr = r_stack_q;
            end
            ST_SCAN: w_push = w_any;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_sp        <= '0;
            r_visited   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_accept && i_in.action == ACT_WALK && w_src_ok) begin
                r_visited <= NODES'(1) << w_src;
                r_sp      <= SP_W'(1);
            end else if (w_pop) begin
                r_sp <= w_sp_dec;
            end else if (r_state == ST_SCAN && w_any) begin
                r_visited <= r_visited | w_low;
                r_sp      <= r_sp + SP_W'(1);
            end
            if (r_state == ST_RESULT && w_slot_free) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_from  <= w_src;
            r_to    <= w_dst;
            r_walk  <= (i_in.action == ACT_WALK);
            r_count <= (i_in.action == ACT_WALK && w_src_ok) ? CNT_W'(1) : '0;
        end else if (r_state == ST_SCAN && w_any) begin
            r_count <= r_count + CNT_W'(1);
        end
        if (r_state == ST_RESULT && w_slot_free) begin
            r_out.reachable_count <= COUNT_W'(r_count);
            r_out.walk_done       <= r_walk;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_stack[w_push_addr] <= w_push_data;
        end
        if (w_pop) begin
            r_stack_q <= r_stack[w_sp_dec[NODE_W-1:0]];
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

`ifndef SYNTH
    a_count_matches_marks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP || r_state == ST_FETCH || r_state == ST_SCAN)
            |-> ($countones(r_visited) == int'(r_count)))
        else $error("walk count differs from visited marks");

    a_stack_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_POP || r_state == ST_FETCH || r_state == ST_SCAN)
            |-> (r_sp <= SP_W'(NODES)))
        else $error("walk stack overflow");

    a_clear_sweeps: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_CLEAR && $past(r_state) == ST_IDLE) |-> w_adj_busy)
        else $error("clear did not start the zeroing pass");

    a_non_walk_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_out.walk_done) |-> (o_out.reachable_count == '0))
        else $error("nonzero count on a non-walk result");
`endif

endmodule

// ===== verif/testbench.sv =====
module testbench;
    import grc_pkg::*;

    localparam int NODES = DEF_NODES;
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;
    localparam int RANDOM_ITEMS = 600;
    localparam int WALK_CYCLES = 4 * NODES + 8;
    localparam int SCRIPT_LEN = 25;

    typedef logic [NODE_ID_W-1:0] t_node;

    typedef struct packed {
        t_action              action;
        t_node                from_node;
        t_node                to_node;
        logic                 typed;
        logic [COUNT_W-1:0]   count;
        logic                 done;
    } t_script_row;

    logic i_clk;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_ready;
    t_in  i_in;
    logic o_out_valid;
    logic i_out_ready;
    t_out o_out;

    graph_reachability_counter_top #(.NODES(NODES)) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out)
    );

    // predictor state: row t holds bit h for edge t -> h
    logic [NODES-1:0] adj_rows [NODES];
    t_out awaited_answers [$];
    t_out oldest;

    int  mismatches;
    int  issued;
    int  n_adds, n_clears, n_walks, n_unused;
    int  largest_count;
    bit  sender_idle;
    bit  sink_idle;
    int  sink_stall;

    // directed part: empty-graph walks, extremes of node ids, self loops,
    // repeated edges, the unused action code and clears
    t_script_row script [SCRIPT_LEN] = '{
        '{ACT_WALK,  6'd0,  6'd0,  1'b1, 7'd1, 1'b1},
        '{ACT_WALK,  6'd63, 6'd63, 1'b1, 7'd1, 1'b1},
        '{ACT_ADD,   6'd0,  6'd63, 1'b1, 7'd0, 1'b0},
        '{ACT_ADD,   6'd63, 6'd0,  1'b1, 7'd0, 1'b0},
        '{ACT_WALK,  6'd0,  6'd0,  1'b0, 7'd0, 1'b0},
        '{ACT_WALK,  6'd63, 6'd21, 1'b0, 7'd0, 1'b0},
        '{ACT_ADD,   6'd5,  6'd5,  1'b1, 7'd0, 1'b0},
        '{ACT_ADD,   6'd5,  6'd5,  1'b1, 7'd0, 1'b0},
        '{ACT_WALK,  6'd5,  6'd42, 1'b1, 7'd1, 1'b1},
        '{ACT_ADD,   6'd0,  6'd63, 1'b1, 7'd0, 1'b0},
        '{t_action'(ACT_UNUSED), 6'd63, 6'd63, 1'b1, 7'd0, 1'b0},
        '{t_action'(ACT_UNUSED), 6'd0,  6'd0,  1'b1, 7'd0, 1'b0},
        '{ACT_ADD,   6'd1,  6'd2,  1'b1, 7'd0, 1'b0},
        '{ACT_ADD,   6'd2,  6'd3,  1'b1, 7'd0, 1'b0},
        '{ACT_ADD,   6'd3,  6'd1,  1'b1, 7'd0, 1'b0},
        '{ACT_ADD,   6'd3,  6'd42, 1'b1, 7'd0, 1'b0},
        '{ACT_ADD,   6'd42, 6'd21, 1'b1, 7'd0, 1'b0},
        '{ACT_WALK,  6'd1,  6'd0,  1'b0, 7'd0, 1'b0},
        '{ACT_WALK,  6'd21, 6'd0,  1'b0, 7'd0, 1'b0},
        '{ACT_CLEAR, 6'd0,  6'd0,  1'b1, 7'd0, 1'b0},
        '{ACT_WALK,  6'd0,  6'd0,  1'b1, 7'd1, 1'b1},
        '{ACT_CLEAR, 6'd63, 6'd63, 1'b1, 7'd0, 1'b0},
        '{ACT_WALK,  6'd42, 6'd21, 1'b1, 7'd1, 1'b1},
        '{ACT_ADD,   6'd21, 6'd42, 1'b1, 7'd0, 1'b0},
        '{ACT_WALK,  6'd21, 6'd63, 1'b0, 7'd0, 1'b0}
    };

    function automatic logic [COUNT_W-1:0] count_reachable(input t_node src);
        logic [NODES-1:0] seen;
        t_node            to_visit [$];
        t_node            node;
        int               total;
        if (int'(src) >= NODES)
            return '0;
        seen = '0;
        seen[src] = 1'b1;
        total = 1;
        to_visit.push_back(src);
        while (to_visit.size() != 0) begin
            node = to_visit.pop_back();
            for (int n = 0; n < NODES; n++) begin
                if (adj_rows[node][n] && !seen[n]) begin
                    seen[n] = 1'b1;
                    total++;
                    to_visit.push_back(t_node'(n));
                end
            end
        end
        return total[COUNT_W-1:0];
    endfunction

    // updates the graph copy and returns the answer for one transaction
    function automatic t_out graph_step(input t_in item);
        t_out answer;
        answer = '0;
        case (item.action)
            ACT_ADD: begin
                if (int'(item.from_node) < NODES && int'(item.to_node) < NODES)
                    adj_rows[item.from_node][item.to_node] = 1'b1;
                n_adds++;
            end
            ACT_CLEAR: begin
                foreach (adj_rows[r])
                    adj_rows[r] = '0;
                n_clears++;
            end
            ACT_WALK: begin
                answer.reachable_count = count_reachable(item.from_node);
                answer.walk_done = 1'b1;
                n_walks++;
            end
            default: begin
                n_unused++;
            end
        endcase
        return answer;
    endfunction

    task automatic issue(input t_in item, input bit typed, input t_out typed_answer);
        t_out predicted;
        if (sender_idle && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge i_clk);
        end
        i_in       <= item;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        predicted = graph_step(item);
        awaited_answers.push_back(typed ? typed_answer : predicted);
        issued++;
        @(negedge i_clk);
    endtask

    task automatic send(input t_action action, input t_node from_node, input t_node to_node);
        t_in item;
        item.action    = action;
        item.from_node = from_node;
        item.to_node   = to_node;
        issue(item, 1'b0, '0);
    endtask

    // an edge add, sometimes preceded by a walk inside the window or by noise
    task automatic add_mixed(input t_node tail, input t_node head, input t_node lo, input int span);
        if ($urandom_range(0, 4) == 0)
            send(ACT_WALK, lo + t_node'($urandom_range(0, span)), t_node'($urandom));
        if ($urandom_range(0, 39) == 0)
            send(t_action'(ACT_UNUSED), t_node'($urandom), t_node'($urandom));
        if ($urandom_range(0, 59) == 0)
            send(ACT_WALK, t_node'($urandom), t_node'($urandom));
        send(ACT_ADD, tail, head);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        while (awaited_answers.size() != 0)
            @(negedge i_clk);
    endtask

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // result side: random ready bursts
    initial begin
        i_out_ready = 1'b0;
        sink_stall = 0;
        forever begin
            @(negedge i_clk);
            if (sink_stall > 0) begin
                sink_stall--;
                i_out_ready <= 1'b0;
            end else if (sink_idle && $urandom_range(0, 5) == 0) begin
                sink_stall = $urandom_range(1, 6) - 1;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (awaited_answers.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected transaction, expected none, actual count=%0d done=%0b",
                         $time, o_out.reachable_count, o_out.walk_done);
            end else begin
                oldest = awaited_answers.pop_front();
                if (o_out.reachable_count !== oldest.reachable_count) begin
                    mismatches++;
                    $display("%0t: reachable_count expected %0d actual %0d",
                             $time, oldest.reachable_count, o_out.reachable_count);
                end
                if (o_out.walk_done !== oldest.walk_done) begin
                    mismatches++;
                    $display("%0t: walk_done expected %0b actual %0b",
                             $time, oldest.walk_done, o_out.walk_done);
                end
                if (int'(o_out.reachable_count) > largest_count)
                    largest_count = int'(o_out.reachable_count);
            end
        end
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    initial begin
        t_in   item;
        t_out  answer;
        t_node lo;
        int    span;
        int    kind;
        int    seg;

        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in       = '0;
        mismatches = 0;
        issued     = 0;
        n_adds     = 0;
        n_clears   = 0;
        n_walks    = 0;
        n_unused   = 0;
        largest_count = 0;
        sender_idle = 1'b1;
        sink_idle   = 1'b1;
        foreach (adj_rows[r])
            adj_rows[r] = '0;

        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (script[i]) begin
            item.action    = script[i].action;
            item.from_node = script[i].from_node;
            item.to_node   = script[i].to_node;
            answer.reachable_count = script[i].count;
            answer.walk_done       = script[i].done;
            issue(item, script[i].typed, answer);
        end
        drain();

        seg = 0;
        while (issued < SCRIPT_LEN + RANDOM_ITEMS) begin
            if (issued > SCRIPT_LEN + (RANDOM_ITEMS * 85) / 100) begin
                sender_idle = 1'b0;
                sink_idle   = 1'b0;
            end else begin
                sender_idle = ($urandom_range(0, 4) != 0);
                sink_idle   = ($urandom_range(0, 4) != 0);
            end

            lo   = t_node'($urandom);
            span = ($urandom_range(0, 5) == 0) ? NODES - 1 : $urandom_range(1, 20);
            kind = $urandom_range(0, 2);
            if (seg == 0) begin
                // full ring over every node: each walk after the ring is closed reaches all of them
                lo   = '0;
                span = NODES - 1;
                kind = 0;
            end
            if (seg == 0 || $urandom_range(0, 1) == 0)
                send(ACT_CLEAR, t_node'($urandom), t_node'($urandom));

            case (kind)
                0: begin
                    for (int k = 0; k < span; k++)
                        add_mixed(lo + t_node'(k), lo + t_node'(k + 1), lo, span);
                    if (seg == 0 || $urandom_range(0, 1) == 0)
                        add_mixed(lo + t_node'(span), lo, lo, span);
                end
                1: begin
                    repeat ($urandom_range(1, 40))
                        add_mixed(lo + t_node'($urandom_range(0, span)),
                                  lo + t_node'($urandom_range(0, span)), lo, span);
                end
                default: begin
                    repeat ($urandom_range(1, 12))
                        add_mixed(t_node'($urandom), t_node'($urandom), lo, span);
                end
            endcase

            repeat ($urandom_range(2, 4))
                send(ACT_WALK, lo + t_node'($urandom_range(0, span)), t_node'($urandom));

            if (seg == 0 || $urandom_range(0, 3) == 0)
                drain();
            seg++;
        end

        drain();
        repeat (WALK_CYCLES) @(negedge i_clk);

        $display("ran %0d transactions: %0d edge adds, %0d clears, %0d walks, %0d unused code",
                 issued, n_adds, n_clears, n_walks, n_unused);
        $display("graph segments: %0d, largest reachable set returned: %0d nodes",
                 seg, largest_count);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/grc_pkg.sv
rtl/grc_adj_store.sv
rtl/graph_reachability_counter_top.sv
verif/testbench.sv
